/* sv/mlbf_pkg.sv */
// ----------------------------------------------------------------------------
// mlbf_pkg
// Types, constants and helper functions shared by the MAC learning bridge
// forwarding block.
// ----------------------------------------------------------------------------
package mlbf_pkg;

  localparam int unsigned MAX_PORTS = 8;
  localparam int unsigned PORT_W    = 3;
  localparam int unsigned MAC_W     = 48;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned APC_W     = 4;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PADDR_W   = 3;

  localparam logic [APC_W-1:0] ACTIVE_PORTS_RST = APC_W'(MAX_PORTS);

  // register index, taken from paddr[2]
  localparam logic REG_ACTIVE_PORTS = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
    logic out_busy;
  } stat_t;

  function automatic logic [MASK_W-1:0] active_mask(input logic [APC_W-1:0] n);
    logic [APC_W-1:0] c;
    logic [MASK_W:0]  m;
    c = n;
    if (c == '0) begin
      c = APC_W'(1);
    end
    if (c > APC_W'(MAX_PORTS)) begin
      c = APC_W'(MAX_PORTS);
    end
    m = ((MASK_W + 1)'(1) << c) - (MASK_W + 1)'(1);
    return m[MASK_W-1:0];
  endfunction

  function automatic logic [MASK_W-1:0] port_bit(input logic [PORT_W-1:0] p);
    return MASK_W'(1) << p;
  endfunction

endpackage

/* sv/mlbf_ctrl.sv */
// ----------------------------------------------------------------------------
// mlbf_ctrl
// Sequencer for one frame header: accept, scan the table and drain the read
// pipeline (not with an empty table), commit learning and forwarding result.
// ----------------------------------------------------------------------------
module mlbf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  mlbf_pkg::stat_t stat,
  output mlbf_pkg::cmd_t  cmd
);
  import mlbf_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.empty ? ST_COMMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!stat.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_DRAIN: begin
        cmd = '0;
      end
      ST_COMMIT: begin
        cmd.commit = !stat.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* sv/mlbf_datapath.sv */
// ----------------------------------------------------------------------------
// mlbf_datapath
// Address table memory, scan compare for source and destination, learning
// write and the registered forwarding result.
// ----------------------------------------------------------------------------
module mlbf_datapath #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mlbf_pkg::cmd_t                  cmd,
  output mlbf_pkg::stat_t                 stat,
  input  logic [mlbf_pkg::MAC_W-1:0]      in_dest_mac,
  input  logic [mlbf_pkg::MAC_W-1:0]      in_src_mac,
  input  logic [mlbf_pkg::PORT_W-1:0]     in_ingress_port,
  input  logic [mlbf_pkg::MASK_W-1:0]     amask,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mlbf_pkg::MASK_W-1:0]     out_forward_mask,
  output logic                            out_dest_known,
  output logic                            out_src_added,
  output logic                            out_src_moved,
  output logic                            out_table_full
);
  import mlbf_pkg::*;

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

  logic [MAC_W-1:0]  mac_mem  [TABLE_ENTRIES];
  logic [PORT_W-1:0] port_mem [TABLE_ENTRIES];

  logic [MAC_W-1:0]  dmac_r;
  logic [MAC_W-1:0]  smac_r;
  logic [PORT_W-1:0] iport_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic [AW-1:0]     scan_addr_r;
  logic              rd_vld_r;
  logic [AW-1:0]     rd_idx_r;
  logic [MAC_W-1:0]  rd_mac_r;
  logic [PORT_W-1:0] rd_port_r;

  logic              s_hit_r;
  logic [AW-1:0]     s_idx_r;
  logic [PORT_W-1:0] s_port_r;
  logic              d_hit_r;
  logic [PORT_W-1:0] d_port_r;

  logic              out_valid_r;
  logic [MASK_W-1:0] mask_r;
  logic              known_r;
  logic              added_r;
  logic              moved_r;
  logic              full_r;

  logic              room;
  logic              added;
  logic              moved;
  logic              full;
  logic              known;
  logic [PORT_W-1:0] dport;
  logic [MASK_W-1:0] mask;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mac_mem[mem_wa]  <= smac_r;
      port_mem[mem_wa] <= iport_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_mac_r  <= mac_mem[scan_addr_r];
      rd_port_r <= port_mem[scan_addr_r];
      rd_idx_r  <= scan_addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      count_r  <= '0;
    end else begin
      rd_vld_r <= cmd.scan;
      count_r  <= count_nxt;
    end
  end

  // hold the header, step the scan address
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dmac_r      <= in_dest_mac;
      smac_r      <= in_src_mac;
      iport_r     <= in_ingress_port;
      scan_addr_r <= '0;
    end else if (cmd.scan) begin
      scan_addr_r <= scan_addr_r + AW'(1);
    end
  end

  // compare each entry against source and destination
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_hit_r <= 1'b0;
      d_hit_r <= 1'b0;
    end else if (cmd.load) begin
      s_hit_r <= 1'b0;
      d_hit_r <= 1'b0;
    end else if (rd_vld_r) begin
      if (!s_hit_r && (rd_mac_r == smac_r)) begin
        s_hit_r <= 1'b1;
      end
      if (!d_hit_r && (rd_mac_r == dmac_r)) begin
        d_hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r && !s_hit_r && (rd_mac_r == smac_r)) begin
      s_idx_r  <= rd_idx_r;
      s_port_r <= rd_port_r;
    end
    if (rd_vld_r && !d_hit_r && (rd_mac_r == dmac_r)) begin
      d_port_r <= rd_port_r;
    end
  end

  // learning and forwarding decision
  always_comb begin
    room  = (count_r < FULL_COUNT);
    added = !s_hit_r && room;
    full  = !s_hit_r && !room;
    moved = s_hit_r && (s_port_r != iport_r);
    if ((dmac_r == smac_r) && (s_hit_r || added)) begin
      known = 1'b1;
      dport = iport_r;
    end else begin
      known = d_hit_r;
      dport = d_port_r;
    end
    if (!known) begin
      mask = amask & ~port_bit(iport_r);
    end else if (dport == iport_r) begin
      mask = '0;
    end else begin
      mask = port_bit(dport) & amask;
    end
    mem_we    = cmd.commit && (added || moved);
    mem_wa    = added ? count_r[AW-1:0] : s_idx_r;
    count_nxt = (cmd.commit && added) ? count_r + CW'(1) : count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      mask_r  <= mask;
      known_r <= known;
      added_r <= added;
      moved_r <= moved;
      full_r  <= full;
    end
  end

  assign stat.empty    = (count_r == '0);
  assign stat.last     = (CW'(scan_addr_r) == (count_r - CW'(1)));
  assign stat.out_busy = out_valid_r && out_stall;

  assign out_valid        = out_valid_r;
  assign out_forward_mask = mask_r;
  assign out_dest_known   = known_r;
  assign out_src_added    = added_r;
  assign out_src_moved    = moved_r;
  assign out_table_full   = full_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("entry count beyond table size");

  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($countones({added_r, moved_r, full_r}) <= 1))
    else $error("more than one learning flag set");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid_r && out_stall))
    else $error("commit over a pending transaction");

  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit without result");

endmodule

/* sv/mac_learning_bridge_forward.sv */
// ----------------------------------------------------------------------------
// mac_learning_bridge_forward
// Ethernet MAC learning bridge: learn source, look up destination, produce
// the forwarding port mask for each frame header.
// ----------------------------------------------------------------------------
//   channel  handshake             payload
//   in       in_valid / in_stall   in_dest_mac, in_src_mac, in_ingress_port
//   out      out_valid / out_stall out_forward_mask, out_dest_known,
//                                  out_src_added, out_src_moved, out_table_full
//   config   psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// A header's scan covers the N valid entries (none with an empty table):
// the table's single read port scans one entry per cycle.
// Reset empties the table through the fill count; no clearing pass.
// A held result stalls only the commit step; the next header may be accepted.
// ----------------------------------------------------------------------------
module mac_learning_bridge_forward #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mlbf_pkg::MAC_W-1:0]      in_dest_mac,
  input  logic [mlbf_pkg::MAC_W-1:0]      in_src_mac,
  input  logic [mlbf_pkg::PORT_W-1:0]     in_ingress_port,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mlbf_pkg::MASK_W-1:0]     out_forward_mask,
  output logic                            out_dest_known,
  output logic                            out_src_added,
  output logic                            out_src_moved,
  output logic                            out_table_full,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mlbf_pkg::PADDR_W-1:0]    paddr,
  input  logic [mlbf_pkg::DATA_W-1:0]     pwdata,
  output logic [mlbf_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);
  import mlbf_pkg::*;

  cmd_t              cmd;
  stat_t             stat;
  logic [APC_W-1:0]  active_ports_r;
  logic [MASK_W-1:0] amask;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_ports_r <= ACTIVE_PORTS_RST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_ACTIVE_PORTS)) begin
      active_ports_r <= pwdata[APC_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ACTIVE_PORTS) begin
      prdata = DATA_W'(active_ports_r);
    end
  end

  assign amask = active_mask(active_ports_r);

  mlbf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mlbf_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_dest_mac      (in_dest_mac),
    .in_src_mac       (in_src_mac),
    .in_ingress_port  (in_ingress_port),
    .amask            (amask),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_forward_mask (out_forward_mask),
    .out_dest_known   (out_dest_known),
    .out_src_added    (out_src_added),
    .out_src_moved    (out_src_moved),
    .out_table_full   (out_table_full)
  );

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// MAC learning bridge forwarding testbench
// Drives frame headers through the valid/stall input channel. Each accepted
// transaction runs through a local forwarding-table predictor. Every result
// transaction is compared field by field in order. The port count register
// is rewritten between phases, and sender and receiver idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  import mlbf_pkg::*;

  localparam int TBL_DEPTH  = 64;
  localparam int POOL_SIZE  = 72;
  localparam int QUIET_MAX  = 4000;
  localparam int HOLD_LEN   = 400;
  localparam int SETTLE_CYC = 80;

  typedef struct packed {
    logic [MAC_W-1:0]  dmac;
    logic [MAC_W-1:0]  smac;
    logic [PORT_W-1:0] port;
  } hdr_t;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic              known;
    logic              added;
    logic              moved;
    logic              full;
  } fwd_t;

  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                in_valid         = 1'b0;
  logic                in_stall;
  logic [MAC_W-1:0]    in_dest_mac      = '0;
  logic [MAC_W-1:0]    in_src_mac       = '0;
  logic [PORT_W-1:0]   in_ingress_port  = '0;
  logic                out_valid;
  logic                out_stall        = 1'b0;
  logic [MASK_W-1:0]   out_forward_mask;
  logic                out_dest_known;
  logic                out_src_added;
  logic                out_src_moved;
  logic                out_table_full;
  logic                psel             = 1'b0;
  logic                penable          = 1'b0;
  logic                pwrite           = 1'b0;
  logic [PADDR_W-1:0]  paddr            = '0;
  logic [DATA_W-1:0]   pwdata           = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  hdr_t hdr_pending[$];
  fwd_t fwd_expected[$];

  // forwarding table mirror
  logic              tbl_valid[TBL_DEPTH];
  logic [MAC_W-1:0]  tbl_mac[TBL_DEPTH];
  logic [PORT_W-1:0] tbl_port[TBL_DEPTH];
  int                tbl_count = 0;
  logic [APC_W-1:0]  act_ports = ACTIVE_PORTS_RST;

  logic [MAC_W-1:0]  mac_pool[POOL_SIZE];
  logic [PORT_W-1:0] home_port[POOL_SIZE];

  int   send_pct      = 0;
  int   recv_pct      = 0;
  logic long_hold_arm = 1'b0;
  logic hold_done     = 1'b0;
  int   hold_cnt      = 0;
  int   quiet_cnt     = 0;
  int   mismatches    = 0;

  mac_learning_bridge_forward DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_dest_mac      (in_dest_mac),
    .in_src_mac       (in_src_mac),
    .in_ingress_port  (in_ingress_port),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_forward_mask (out_forward_mask),
    .out_dest_known   (out_dest_known),
    .out_src_added    (out_src_added),
    .out_src_moved    (out_src_moved),
    .out_table_full   (out_table_full),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #4 clk = ~clk;

  function automatic int find_entry(input logic [MAC_W-1:0] mac);
    for (int i = 0; i < TBL_DEPTH; i++) begin
      if (tbl_valid[i] && tbl_mac[i] == mac) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic fwd_t predict_forward(input hdr_t h);
    fwd_t             r;
    int               s_idx;
    int               d_idx;
    logic [APC_W-1:0] n;
    logic [MASK_W-1:0] amask;
    r = '0;
    n = act_ports;
    if (n == 0) begin
      n = APC_W'(1);
    end
    if (n > MAX_PORTS) begin
      n = APC_W'(MAX_PORTS);
    end
    amask = MASK_W'((9'd1 << n) - 9'd1);
    s_idx = find_entry(h.smac);
    if (s_idx < 0) begin
      if (tbl_count < TBL_DEPTH) begin
        tbl_valid[tbl_count] = 1'b1;
        tbl_mac[tbl_count]   = h.smac;
        tbl_port[tbl_count]  = h.port;
        tbl_count++;
        r.added = 1'b1;
      end else begin
        r.full = 1'b1;
      end
    end else if (tbl_port[s_idx] != h.port) begin
      tbl_port[s_idx] = h.port;
      r.moved = 1'b1;
    end
    d_idx = find_entry(h.dmac);
    if (d_idx < 0) begin
      r.mask = amask & ~(MASK_W'(1) << h.port);
    end else begin
      r.known = 1'b1;
      if (tbl_port[d_idx] == h.port) begin
        r.mask = '0;
      end else begin
        r.mask = (MASK_W'(1) << tbl_port[d_idx]) & amask;
      end
    end
    return r;
  endfunction

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[MAC_W-1:0];
  endfunction

  function automatic hdr_t random_hdr();
    hdr_t h;
    int   k;
    int   sel;
    sel = $urandom_range(99);
    if (sel < 75) begin
      k = $urandom_range(POOL_SIZE - 1);
      if ($urandom_range(99) < 4) begin
        home_port[k] = PORT_W'($urandom_range(7));
      end
      h.smac = mac_pool[k];
      h.port = ($urandom_range(99) < 80) ? home_port[k] : PORT_W'($urandom_range(7));
    end else begin
      h.smac = rand_mac();
      h.port = PORT_W'($urandom_range(7));
    end
    sel = $urandom_range(99);
    if (sel < 55) begin
      h.dmac = mac_pool[$urandom_range(POOL_SIZE - 1)];
    end else if (sel < 75) begin
      h.dmac = h.smac;
    end else if (sel < 90) begin
      h.dmac = rand_mac();
    end else begin
      h.dmac = '1;
    end
    return h;
  endfunction

  function automatic hdr_t mk_hdr(input logic [MAC_W-1:0] d, input logic [MAC_W-1:0] s,
                                  input logic [PORT_W-1:0] p);
    hdr_t h;
    h.dmac = d;
    h.smac = s;
    h.port = p;
    return h;
  endfunction

  function automatic void check_field(input string name, input int unsigned e,
                                      input int unsigned a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
      mismatches++;
    end
  endfunction

  task automatic write_active(input logic [APC_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_ACTIVE_PORTS, 2'b00};
    pwdata  <= DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    act_ports = v;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (!(hdr_pending.size() == 0 && !in_valid && fwd_expected.size() == 0)) begin
      @(negedge clk);
    end
  endtask

  task automatic push_random(input int count);
    for (int i = 0; i < count; i++) begin
      hdr_pending.push_back(random_hdr());
    end
  endtask

  // driver: advance to the next header once the current transaction is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        fwd_expected.push_back(predict_forward(mk_hdr(in_dest_mac, in_src_mac,
                                                      in_ingress_port)));
      end
      if (!in_valid || !in_stall) begin
        if (hdr_pending.size() > 0 && $urandom_range(99) >= send_pct) begin
          hdr_t h;
          h = hdr_pending.pop_front();
          in_dest_mac     <= h.dmac;
          in_src_mac      <= h.smac;
          in_ingress_port <= h.port;
          in_valid        <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check result transactions and drive receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (fwd_expected.size() == 0) begin
          $display("%0t: unexpected result, mask %0h known %0b added %0b moved %0b full %0b",
                   $time, out_forward_mask, out_dest_known, out_src_added, out_src_moved,
                   out_table_full);
          mismatches++;
        end else begin
          fwd_t e;
          e = fwd_expected.pop_front();
          check_field("forward_mask", 32'(e.mask), 32'(out_forward_mask));
          check_field("dest_known", 32'(e.known), 32'(out_dest_known));
          check_field("src_added", 32'(e.added), 32'(out_src_added));
          check_field("src_moved", 32'(e.moved), 32'(out_src_moved));
          check_field("table_full", 32'(e.full), 32'(out_table_full));
        end
      end
      if (long_hold_arm && !hold_done) begin
        hold_cnt  <= HOLD_LEN;
        hold_done <= 1'b1;
        out_stall <= 1'b1;
      end else if (hold_cnt > 0) begin
        hold_cnt  <= hold_cnt - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_pct);
      end
    end
  end

  // watchdog: count cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cnt <= 0;
      end else if (quiet_cnt >= QUIET_MAX) begin
        $display("[mac_learning_bridge_forward] ERROR");
        $finish;
      end else begin
        quiet_cnt <= quiet_cnt + 1;
      end
    end
  end

  initial begin
    logic [MAC_W-1:0] mac_a;
    logic [MAC_W-1:0] mac_b;
    logic [MAC_W-1:0] mac_c;
    logic [MAC_W-1:0] mac_d;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_mac[i]   = '0;
      tbl_port[i]  = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) begin
      mac_pool[i]  = rand_mac();
      home_port[i] = PORT_W'($urandom_range(7));
    end
    mac_a = rand_mac();
    mac_b = rand_mac();
    mac_c = rand_mac();
    mac_d = rand_mac();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    write_active(APC_W'(4));
    hdr_pending.push_back(mk_hdr('1, '0, 3'd0));
    hdr_pending.push_back(mk_hdr('0, '1, 3'd7));
    hdr_pending.push_back(mk_hdr('1, mac_a, 3'd1));
    hdr_pending.push_back(mk_hdr(mac_a, mac_a, 3'd1));
    hdr_pending.push_back(mk_hdr(mac_b, mac_a, 3'd2));
    hdr_pending.push_back(mk_hdr(mac_a, mac_b, 3'd2));
    hdr_pending.push_back(mk_hdr(mac_b, mac_c, 3'd3));
    hdr_pending.push_back(mk_hdr(mac_c, mac_c, 3'd5));
    hdr_pending.push_back(mk_hdr('1, '1, 3'd7));
    hdr_pending.push_back(mk_hdr({24{2'b10}}, {24{2'b01}}, 3'd5));
    hdr_pending.push_back(mk_hdr({24{2'b01}}, {24{2'b10}}, 3'd2));
    hdr_pending.push_back(mk_hdr(mac_c, mac_b, 3'd6));
    wait_drained();

    write_active(APC_W'(0));
    hdr_pending.push_back(mk_hdr(mac_d, mac_d, 3'd0));
    hdr_pending.push_back(mk_hdr(rand_mac(), mac_a, 3'd0));
    hdr_pending.push_back(mk_hdr(rand_mac(), mac_b, 3'd3));
    hdr_pending.push_back(mk_hdr(mac_c, mac_a, 3'd4));
    wait_drained();

    write_active(APC_W'(15));
    hdr_pending.push_back(mk_hdr(rand_mac(), mac_b, 3'd4));
    hdr_pending.push_back(mk_hdr(mac_a, mac_c, 3'd7));
    wait_drained();

    send_pct = 38;
    recv_pct = 61;
    write_active(APC_W'(8));
    push_random(450);
    wait_drained();

    send_pct = 61;
    recv_pct = 38;
    write_active(APC_W'($urandom_range(2, 7)));
    push_random(450);
    wait_drained();

    send_pct = 0;
    recv_pct = 0;
    write_active(APC_W'(1));
    push_random(225);
    repeat (30) @(negedge clk);
    long_hold_arm = 1'b1;
    wait_drained();

    write_active(APC_W'(8));
    push_random(225);
    wait_drained();

    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatches == 0 && fwd_expected.size() == 0) begin
      $display("[mac_learning_bridge_forward] OK");
    end else begin
      $display("[mac_learning_bridge_forward] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/mlbf_pkg.sv
sv/mlbf_ctrl.sv
sv/mlbf_datapath.sv
sv/mac_learning_bridge_forward.sv
verif/testbench.sv
